/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion helpers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/psls_pkg.sv */
// ----------------------------------------------------------------------------
// psls_pkg
// shared types and constants of the pose setpoint smoother
// ----------------------------------------------------------------------------
`default_nettype none
package psls_pkg;

  localparam int VEC_W   = 52;
  localparam int ANG_W   = 34;
  localparam int TAB_LEN = 24;
  localparam int STEP_W  = 5;

  localparam logic [16:0] GAIN_ONE   = 17'd65536;
  localparam logic [16:0] GAIN_RESET = 17'd6554;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [ANG_W-1:0] INV_GAIN_Q30 = 34'sd652032874;

  typedef struct packed {
    logic                    zero_yaw;
    logic signed [VEC_W-1:0] vec_a;
    logic signed [VEC_W-1:0] vec_b;
    logic signed [ANG_W-1:0] ang;
  } vec_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_VEC,
    BK_FILT,
    BK_ROT,
    BK_DONE
  } bk_state_t;

  function automatic logic signed [ANG_W-1:0] angle_at(input logic [STEP_W-1:0] idx);
    logic signed [ANG_W-1:0] v;
    unique case (idx)
      5'd0:    v = 34'sd536870912;
      5'd1:    v = 34'sd316933406;
      5'd2:    v = 34'sd167458907;
      5'd3:    v = 34'sd85004756;
      5'd4:    v = 34'sd42667331;
      5'd5:    v = 34'sd21354465;
      5'd6:    v = 34'sd10679838;
      5'd7:    v = 34'sd5340245;
      5'd8:    v = 34'sd2670163;
      5'd9:    v = 34'sd1335087;
      5'd10:   v = 34'sd667544;
      5'd11:   v = 34'sd333772;
      5'd12:   v = 34'sd166886;
      5'd13:   v = 34'sd83443;
      5'd14:   v = 34'sd41722;
      5'd15:   v = 34'sd20861;
      5'd16:   v = 34'sd10430;
      5'd17:   v = 34'sd5215;
      5'd18:   v = 34'sd2608;
      5'd19:   v = 34'sd1304;
      5'd20:   v = 34'sd652;
      5'd21:   v = 34'sd326;
      5'd22:   v = 34'sd163;
      5'd23:   v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* rtl/psls_front.sv */
// ----------------------------------------------------------------------------
// psls_front
// takes a setpoint, forms the yaw vector terms and the starting half plane
// ----------------------------------------------------------------------------
`default_nettype none
module psls_front import psls_pkg::*; #(
  parameter int PB = 32
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire  signed [PB-1:0]     pos_x,
  input  wire  signed [PB-1:0]     pos_y,
  input  wire  signed [PB-1:0]     pos_z,
  input  wire  signed [15:0]       quat_w,
  input  wire  signed [15:0]       quat_x,
  input  wire  signed [15:0]       quat_y,
  input  wire  signed [15:0]       quat_z,
  output logic                     push,
  input  wire                      q_full,
  output logic [3*PB-1:0]          push_pos,
  output vec_t                     push_vec
);

  logic                 s1_valid_r;
  logic [3*PB-1:0]      pos_r;
  logic signed [31:0]   ww_r, xx_r, yy_r, zz_r, xz_r, wy_r, xy_r, wz_r;

  logic signed [34:0]   mag_d, tilt_s, tilt_abs;
  logic signed [33:0]   dot_sum, diag_sum;
  logic signed [VEC_W-1:0] a0, b0;

  assign in_ready = !s1_valid_r || !q_full;
  assign push     = s1_valid_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      pos_r <= {pos_z, pos_y, pos_x};
      ww_r  <= quat_w * quat_w;
      xx_r  <= quat_x * quat_x;
      yy_r  <= quat_y * quat_y;
      zz_r  <= quat_z * quat_z;
      xz_r  <= quat_x * quat_z;
      wy_r  <= quat_w * quat_y;
      xy_r  <= quat_x * quat_y;
      wz_r  <= quat_w * quat_z;
    end
  end

  always_comb begin
    mag_d    = {{3{ww_r[31]}}, ww_r} + {{3{xx_r[31]}}, xx_r}
             + {{3{yy_r[31]}}, yy_r} + {{3{zz_r[31]}}, zz_r};
    tilt_s   = ({{3{xz_r[31]}}, xz_r} - {{3{wy_r[31]}}, wy_r}) <<< 1;
    tilt_abs = tilt_s[34] ? -tilt_s : tilt_s;
    dot_sum  = {{2{xy_r[31]}}, xy_r} + {{2{wz_r[31]}}, wz_r};
    diag_sum = {{2{ww_r[31]}}, ww_r} + {{2{xx_r[31]}}, xx_r}
             - {{2{yy_r[31]}}, yy_r} - {{2{zz_r[31]}}, zz_r};
    a0 = {{(VEC_W-51){dot_sum[33]}}, dot_sum, 17'd0};
    b0 = {{(VEC_W-50){diag_sum[33]}}, diag_sum, 16'd0};

    push_pos          = pos_r;
    push_vec.zero_yaw = tilt_abs >= mag_d;
    // left half plane: turn by a quarter first
    if (b0[VEC_W-1]) begin
      if (!a0[VEC_W-1]) begin
        push_vec.vec_b = a0;
        push_vec.vec_a = -b0;
        push_vec.ang   = QUARTER_TURN;
      end else begin
        push_vec.vec_b = -a0;
        push_vec.vec_a = b0;
        push_vec.ang   = -QUARTER_TURN;
      end
    end else begin
      push_vec.vec_b = b0;
      push_vec.vec_a = a0;
      push_vec.ang   = '0;
    end
  end

endmodule
`default_nettype wire

/* rtl/psls_queue.sv */
// ----------------------------------------------------------------------------
// psls_queue
// two-entry queue between the front and back parts
// ----------------------------------------------------------------------------
`default_nettype none
module psls_queue #(
  parameter int W = 8
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          push,
  input  wire  [W-1:0] din,
  output logic         full,
  input  wire          pop,
  output logic [W-1:0] dout,
  output logic         nonempty
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   count_r;

  assign full     = count_r == 2'd2;
  assign nonempty = count_r != 2'd0;
  assign dout     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem_r[wr_ptr_r] <= din;
  end

endmodule
`default_nettype wire

/* rtl/psls_back.sv */
// ----------------------------------------------------------------------------
// psls_back
// yaw cordic, low-pass filter on four channels, heading cordic, output word
// ----------------------------------------------------------------------------
`default_nettype none
module psls_back import psls_pkg::*; #(
  parameter int PB    = 32,
  parameter int STEPS = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  q_nonempty,
  input  wire  [3*PB-1:0]      q_pos,
  input  vec_t                 q_vec,
  output logic                 pop,
  input  wire  [16:0]          gain,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic signed [PB-1:0] smooth_x,
  output logic signed [PB-1:0] smooth_y,
  output logic signed [PB-1:0] smooth_z,
  output logic signed [16:0]   smooth_yaw,
  output logic signed [15:0]   heading_w,
  output logic signed [15:0]   heading_z
);

  localparam int NSTEP = (STEPS > TAB_LEN) ? TAB_LEN : STEPS;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NSTEP - 1);
  localparam int D_W = PB + 1;
  localparam int P_W = D_W + 18;

  bk_state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r;
  logic [1:0]        ch_r;
  logic              first_r;
  logic              zero_r;
  logic [3*PB-1:0]   pos_r;
  logic signed [VEC_W-1:0] va_r, vb_r;
  logic signed [ANG_W-1:0] ang_r;
  logic signed [PB-1:0] held_x_r, held_y_r, held_z_r;
  logic signed [16:0]   held_yaw_r;
  logic signed [ANG_W-1:0] cx_r, cy_r, t_r;

  logic signed [16:0]   yaw_in;
  logic signed [ANG_W-1:0] ang_rnd;
  logic signed [ANG_W-1:0] tab_v;
  logic signed [D_W-1:0] f_in, f_held, f_diff;
  logic signed [P_W-1:0] f_prod;
  logic signed [P_W-1:0] f_step;
  logic signed [D_W-1:0] f_res;
  logic signed [ANG_W-1:0] cx_rnd, cy_rnd;
  logic signed [15:0]   hw_c, hz_c;
  logic                 done_go;

  function automatic logic signed [PB-1:0] q_sel(input int k);
    return pos_r[k*PB +: PB];
  endfunction

  assign tab_v = angle_at(step_r);

  // yaw from the vectoring angle, rounded to 1/65536 and clamped
  always_comb begin
    ang_rnd = (ang_r + 34'sd32768) >>> 16;
    if (zero_r)                       yaw_in = '0;
    else if (ang_rnd > 34'sd32768)    yaw_in = 17'sd32767 + 17'sd1;
    else if (ang_rnd < -34'sd32768)   yaw_in = -17'sd32768;
    else                              yaw_in = ang_rnd[16:0];
  end

  // shared filter datapath, one channel a cycle
  always_comb begin
    unique case (ch_r)
      2'd0: begin
        f_in   = {pos_r[PB-1], pos_r[PB-1:0]};
        f_held = {held_x_r[PB-1], held_x_r};
      end
      2'd1: begin
        f_in   = {pos_r[2*PB-1], pos_r[2*PB-1:PB]};
        f_held = {held_y_r[PB-1], held_y_r};
      end
      2'd2: begin
        f_in   = {pos_r[3*PB-1], pos_r[3*PB-1:2*PB]};
        f_held = {held_z_r[PB-1], held_z_r};
      end
      default: begin
        f_in   = {{(D_W-17){yaw_in[16]}}, yaw_in};
        f_held = {{(D_W-17){held_yaw_r[16]}}, held_yaw_r};
      end
    endcase
    f_diff = f_in - f_held;
    f_prod = f_diff * $signed({1'b0, gain});
    f_step = (f_prod + P_W'(32768)) >>> 16;
    f_res  = f_held + f_step[D_W-1:0];
  end

  always_comb begin
    cx_rnd = (cx_r + 34'sd32768) >>> 16;
    cy_rnd = (cy_r + 34'sd32768) >>> 16;
    if (cx_rnd > 34'sd16384)        hw_c = 16'sd16384;
    else if (cx_rnd < -34'sd16384)  hw_c = -16'sd16384;
    else                            hw_c = cx_rnd[15:0];
    if (cy_rnd > 34'sd16384)        hz_c = 16'sd16384;
    else if (cy_rnd < -34'sd16384)  hz_c = -16'sd16384;
    else                            hz_c = cy_rnd[15:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (q_nonempty) state_nxt = BK_VEC;
      BK_VEC:  if (step_r == LAST_STEP) state_nxt = BK_FILT;
      BK_FILT: if (first_r || ch_r == 2'd3) state_nxt = BK_ROT;
      BK_ROT:  if (step_r == LAST_STEP) state_nxt = BK_DONE;
      BK_DONE: if (!out_valid || out_ready) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop     = (state_r == BK_IDLE) && q_nonempty;
    done_go = (state_r == BK_DONE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_IDLE;
      first_r    <= 1'b1;
      out_valid  <= 1'b0;
      held_x_r   <= '0;
      held_y_r   <= '0;
      held_z_r   <= '0;
      held_yaw_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (done_go)        out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (state_r == BK_FILT) begin
        if (first_r) begin
          // first setpoint loads the filter state
          held_x_r   <= q_sel(0);
          held_y_r   <= q_sel(1);
          held_z_r   <= q_sel(2);
          held_yaw_r <= yaw_in;
          first_r    <= 1'b0;
        end else begin
          unique case (ch_r)
            2'd0:    held_x_r   <= f_res[PB-1:0];
            2'd1:    held_y_r   <= f_res[PB-1:0];
            2'd2:    held_z_r   <= f_res[PB-1:0];
            default: held_yaw_r <= f_res[16:0];
          endcase
        end
      end
    end

    unique case (state_r)
      BK_IDLE: begin
        pos_r  <= q_pos;
        zero_r <= q_vec.zero_yaw;
        va_r   <= q_vec.vec_a;
        vb_r   <= q_vec.vec_b;
        ang_r  <= q_vec.ang;
        step_r <= '0;
        ch_r   <= 2'd0;
      end
      BK_VEC: begin
        if (!va_r[VEC_W-1]) begin
          vb_r  <= vb_r + (va_r >>> step_r);
          va_r  <= va_r - (vb_r >>> step_r);
          ang_r <= ang_r + tab_v;
        end else begin
          vb_r  <= vb_r - (va_r >>> step_r);
          va_r  <= va_r + (vb_r >>> step_r);
          ang_r <= ang_r - tab_v;
        end
        step_r <= (step_r == LAST_STEP) ? '0 : step_r + 1'b1;
      end
      BK_FILT: begin
        ch_r <= ch_r + 2'd1;
        cx_r <= INV_GAIN_Q30;
        cy_r <= '0;
        if (first_r) t_r <= {{(ANG_W-32){yaw_in[16]}}, yaw_in, 15'd0};
        else         t_r <= {{(ANG_W-32){f_res[16]}}, f_res[16:0], 15'd0};
      end
      BK_ROT: begin
        if (!t_r[ANG_W-1]) begin
          cx_r <= cx_r - (cy_r >>> step_r);
          cy_r <= cy_r + (cx_r >>> step_r);
          t_r  <= t_r - tab_v;
        end else begin
          cx_r <= cx_r + (cy_r >>> step_r);
          cy_r <= cy_r - (cx_r >>> step_r);
          t_r  <= t_r + tab_v;
        end
        step_r <= (step_r == LAST_STEP) ? '0 : step_r + 1'b1;
      end
      default: begin
        if (done_go) begin
          smooth_x   <= held_x_r;
          smooth_y   <= held_y_r;
          smooth_z   <= held_z_r;
          smooth_yaw <= held_yaw_r;
          heading_w  <= hw_c;
          heading_z  <= hz_c;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/pose_setpoint_lowpass_smoother.sv */
// ----------------------------------------------------------------------------
// pose_setpoint_lowpass_smoother
// Usage: a setpoint word (three Q16.16 positions, a Q1.14 quaternion) enters
// on in_*; one smoothed word per setpoint leaves on out_*. The front part
// registers the quaternion products, forms the yaw vector terms and drops
// them in a two-entry queue; the back part runs the vectoring cordic, the
// filter on x, y, z and yaw through one shared multiplier (one channel at
// a time; the first setpoint loads all four at once), the heading cordic
// and loads the output register. The back part works on one setpoint at a
// time, which sets the throughput. The filter gain is written on cfg_*
// (always ready); the user must write it only while the block idles, as
// the block itself does not enforce this.
// Reset clears the filter state and arms the first-setpoint load; the gain
// returns to 6554. A stalled out_tready holds the output word; up to four
// more setpoints are taken and wait in the front part, queue and back part.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module pose_setpoint_lowpass_smoother import psls_pkg::*; #(
  parameter int POSITION_BITS = 32,
  parameter int CORDIC_STEPS  = 16
) (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_tvalid,
  output logic in_tready,
  // pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z, zero fill
  input  wire  [((3*POSITION_BITS+71)/8)*8-1:0]  in_tdata,
  output logic out_tvalid,
  input  wire  out_tready,
  // smooth_x, smooth_y, smooth_z, smooth_yaw, heading_w, heading_z, zero fill
  output logic [((3*POSITION_BITS+56)/8)*8-1:0] out_tdata,
  input  wire  cfg_valid,
  output logic cfg_ready,
  input  wire  [16:0] cfg_data
);

  localparam int PB        = POSITION_BITS;
  localparam int OUT_BITS  = 3 * PB + 49;
  localparam int OUT_BYTES = (OUT_BITS + 7) / 8;
  localparam int Q_W       = 3 * PB + $bits(vec_t);

  logic [16:0] gain_r, gain_eff;
  logic        push, q_full, pop, q_nonempty;
  logic [3*PB-1:0] push_pos, q_pos;
  vec_t        push_vec, q_vec;
  logic signed [PB-1:0] sx, sy, sz;
  logic signed [16:0]   syaw;
  logic signed [15:0]   hw, hz;

  assign cfg_ready = 1'b1;
  assign gain_eff  = (gain_r > GAIN_ONE) ? GAIN_ONE : gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      gain_r <= cfg_data;
    end
  end

  psls_front #(.PB(PB)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .pos_x(in_tdata[PB-1:0]), .pos_y(in_tdata[2*PB-1:PB]),
    .pos_z(in_tdata[3*PB-1:2*PB]),
    .quat_w(in_tdata[3*PB+15:3*PB]), .quat_x(in_tdata[3*PB+31:3*PB+16]),
    .quat_y(in_tdata[3*PB+47:3*PB+32]), .quat_z(in_tdata[3*PB+63:3*PB+48]),
    .push(push), .q_full(q_full), .push_pos(push_pos), .push_vec(push_vec)
  );

  psls_queue #(.W(Q_W)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(push), .din({push_pos, push_vec}), .full(q_full),
    .pop(pop), .dout({q_pos, q_vec}), .nonempty(q_nonempty)
  );

  psls_back #(.PB(PB), .STEPS(CORDIC_STEPS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_nonempty(q_nonempty), .q_pos(q_pos), .q_vec(q_vec), .pop(pop),
    .gain(gain_eff),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .smooth_x(sx), .smooth_y(sy), .smooth_z(sz), .smooth_yaw(syaw),
    .heading_w(hw), .heading_z(hz)
  );

  assign out_tdata = {{(OUT_BYTES*8-OUT_BITS){1'b0}}, hz, hw, syaw, sz, sy, sx};

  `CHK_SAME(a_no_push_full, push, !q_full, "push into a full queue")
  `CHK_SAME(a_no_pop_empty, pop, q_nonempty, "pop from an empty queue")
  `CHK_NEXT(a_pop_not_twice, pop, !pop, "back part popped on two cycles in a row")

endmodule
`default_nettype wire

/* dv/tb_pose_setpoint_lowpass_smoother.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pose_setpoint_lowpass_smoother
// Self-checking bench for the pose setpoint smoother. A directed table covers
// the first-setpoint load, gimbal lock, zero and non-unit quaternions,
// half-plane cases and the gain extremes. Random phases at several gains
// follow. Every accepted setpoint is run through a local yaw-cordic, low-pass
// and heading-cordic model. Each output word is checked against the oldest
// prediction. Sender bursts and receiver stalls are randomized.
// ----------------------------------------------------------------------------
module tb_pose_setpoint_lowpass_smoother;

  localparam int STEPS    = 16;
  localparam int IN_W     = 160;
  localparam int OUT_W    = 152;
  localparam int N_RAND   = 250;
  localparam int N_PHASES = 8;

  typedef struct packed {
    logic signed [15:0] hz;
    logic signed [15:0] hw;
    logic signed [16:0] yaw;
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } smooth_word_t;

  typedef struct {
    logic [31:0] px, py, pz;
    logic [15:0] qw, qx, qy, qz;
    int          new_gain;   // -1 keeps the current gain
    bit          typed;
    logic [31:0] tx, ty, tz;
  } setpoint_row_t;

  longint cordic_angles [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [16:0]      cfg_data = '0;

  smooth_word_t smoothed_q [$];
  int           mismatches = 0;
  logic         typed_req = 1'b0;
  logic [31:0]  typed_x = '0, typed_y = '0, typed_z = '0;
  int           hold_trig = 0;

  // model state
  bit     first_pending = 1;
  longint held_x = 0, held_y = 0, held_z = 0, held_yaw = 0;
  longint gain_reg = 6554;

  pose_setpoint_lowpass_smoother i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic longint clamp_to(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint yaw_from_quat(longint w, longint x, longint y, longint z);
    longint d, s, a, b, ang, nx, ny;
    d = w*w + x*x + y*y + z*z;
    s = 2 * (x*z - w*y);
    if (s < 0) s = -s;
    if (s >= d) return 0;
    a = 2 * (x*y + w*z) * 65536;
    b = (w*w + x*x - y*y - z*z) * 65536;
    ang = 0;
    // left half-plane: turn by a quarter first
    if (b < 0) begin
      if (a >= 0) begin
        nx = a; ny = -b; ang = 1073741824;
      end else begin
        nx = -a; ny = b; ang = -1073741824;
      end
      b = nx; a = ny;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (a >= 0) begin
        nx = b + (a >>> i); ny = a - (b >>> i); ang += cordic_angles[i];
      end else begin
        nx = b - (a >>> i); ny = a + (b >>> i); ang -= cordic_angles[i];
      end
      b = nx; a = ny;
    end
    return clamp_to((ang + 32768) >>> 16, 32768);
  endfunction

  function automatic longint lowpass_step(longint in_v, longint y, longint g);
    longint d, hi, lo;
    d  = in_v - y;
    hi = d >>> 16;
    lo = d - hi * 65536;
    return y + hi * g + ((lo * g + 32768) >>> 16);
  endfunction

  function automatic smooth_word_t smooth_setpoint(logic [IN_W-1:0] w);
    longint px, py, pz, yaw, g, t, cx, cy, nx, ny;
    smooth_word_t r;
    px  = longint'($signed(w[31:0]));
    py  = longint'($signed(w[63:32]));
    pz  = longint'($signed(w[95:64]));
    yaw = yaw_from_quat(longint'($signed(w[111:96])), longint'($signed(w[127:112])),
                        longint'($signed(w[143:128])), longint'($signed(w[159:144])));
    g = (gain_reg > 65536) ? 65536 : gain_reg;
    if (first_pending) begin
      held_x = px; held_y = py; held_z = pz; held_yaw = yaw;
      first_pending = 0;
    end
    held_x   = lowpass_step(px, held_x, g);
    held_y   = lowpass_step(py, held_y, g);
    held_z   = lowpass_step(pz, held_z, g);
    held_yaw = lowpass_step(yaw, held_yaw, g);
    t  = held_yaw * 32768;
    cx = 652032874;
    cy = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (t >= 0) begin
        nx = cx - (cy >>> i); ny = cy + (cx >>> i); t -= cordic_angles[i];
      end else begin
        nx = cx + (cy >>> i); ny = cy - (cx >>> i); t += cordic_angles[i];
      end
      cx = nx; cy = ny;
    end
    r.x   = held_x[31:0];
    r.y   = held_y[31:0];
    r.z   = held_z[31:0];
    r.yaw = held_yaw[16:0];
    r.hw  = 16'(clamp_to((cx + 32768) >>> 16, 16384));
    r.hz  = 16'(clamp_to((cy + 32768) >>> 16, 16384));
    return r;
  endfunction

  // prediction and checking, sampled at the edge
  always @(posedge clk) begin
    smooth_word_t exp_w, got_w;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) gain_reg = longint'(cfg_data);
      if (in_tvalid && in_tready) begin
        exp_w = smooth_setpoint(in_tdata);
        if (typed_req) begin
          exp_w.x = typed_x; exp_w.y = typed_y; exp_w.z = typed_z;
        end
        smoothed_q.insert(smoothed_q.size(), exp_w);
      end
      if (out_tvalid && out_tready) begin
        got_w = out_tdata[144:0];
        if (smoothed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", got_w);
        end else begin
          exp_w = smoothed_q.pop_front();
          if (got_w !== exp_w || out_tdata[OUT_W-1:145] !== '0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch x %h/%h y %h/%h z %h/%h yaw %h/%h hw %h/%h hz %h/%h",
                       exp_w.x, got_w.x, exp_w.y, got_w.y, exp_w.z, got_w.z,
                       exp_w.yaw, got_w.yaw, exp_w.hw, got_w.hw, exp_w.hz, got_w.hz);
          end
        end
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk) begin
    static int hold_cnt = 0, seen_trig = 0, mode = 0, win = 0;
    if (hold_trig != seen_trig) begin
      seen_trig = hold_trig;
      hold_cnt = 400;
    end
    if (win == 0) begin
      win  = $urandom_range(20, 120);
      mode = $urandom_range(0, 2);
    end
    win--;
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(0, 1);
        default: out_tready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  task automatic drain_wait();
    while (smoothed_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_gain(int g);
    drain_wait();
    cfg_valid <= 1'b1;
    cfg_data  <= g[16:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_setpoint(logic [31:0] px, py, pz, logic [15:0] qw, qx, qy, qz);
    in_tvalid <= 1'b1;
    in_tdata  <= {qz, qy, qx, qw, pz, py, px};
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [15:0] rand_quat_part();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      case ($urandom_range(0, 2))
        0: return -16'sd16384;
        1: return 16'sd0;
        default: return 16'sd16384;
      endcase
    end
    if (sel == 1) return 16'($signed($urandom_range(0, 400)) - 200);
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic [31:0] rand_position();
    if ($urandom_range(0, 1)) return $urandom;
    return 32'($signed($urandom_range(0, 2097152)) - 1048576);
  endfunction

  setpoint_row_t directed [12];
  int phase_gain [N_PHASES];

  initial begin
    int burst;
    directed[0]  = '{32'h7fffffff, 32'h80000000, 32'h0, 16'sd16384, 0, 0, 0, -1, 1,
                     32'h7fffffff, 32'h80000000, 32'h0};
    directed[1]  = '{0, 0, 32'hffffffff, 0, 0, 0, 0, -1, 0, 0, 0, 0};
    directed[2]  = '{32'h00010000, 32'h00020000, 32'h00030000, 16'sd8192, 0,
                     -16'sd8192, 0, -1, 0, 0, 0, 0};
    directed[3]  = '{32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0, 0, 16'sd16384,
                     -1, 0, 0, 0, 0};
    directed[4]  = '{32'h12345678, 32'hedcba987, 32'h00000001, -16'sd16384,
                     -16'sd16384, -16'sd16384, -16'sd16384, -1, 0, 0, 0, 0};
    directed[5]  = '{0, 0, 0, 16'sd100, 0, 0, 16'sd100, -1, 0, 0, 0, 0};
    directed[6]  = '{32'hffff0000, 32'h0000ffff, 32'h7fff0000, 16'sd16384, 16'sd16384,
                     16'sd16384, 16'sd16384, -1, 0, 0, 0, 0};
    directed[7]  = '{32'h00050000, 32'hfffb0000, 0, 16'sd8192, 0, 0, -16'sd16384,
                     -1, 0, 0, 0, 0};
    // unity gain: output follows the input
    directed[8]  = '{32'h80000000, 32'h7fffffff, 32'h00a5a5a5, 0, 16'sd16384, 0, 0,
                     65536, 1, 32'h80000000, 32'h7fffffff, 32'h00a5a5a5};
    // gain above one acts as one
    directed[9]  = '{32'h7fffffff, 32'h80000000, 32'h5a5a0000, 16'sd11585, 0, 0,
                     16'sd11585, 131071, 1, 32'h7fffffff, 32'h80000000, 32'h5a5a0000};
    // zero gain holds the last state
    directed[10] = '{32'h0, 32'h0, 32'h0, 0, 0, 16'sd16384, 0, 0, 1,
                     32'h7fffffff, 32'h80000000, 32'h5a5a0000};
    directed[11] = '{32'hdeadbeef, 32'h01234567, 32'hfedcba98, -16'sd5000, 16'sd3000,
                     -16'sd2000, 16'sd16000, 1, 0, 0, 0, 0};
    phase_gain = '{6554, 65536, 0, 131071, 1, 32768, 100000, 3000};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].new_gain >= 0) begin
        in_tvalid <= 1'b0;
        write_gain(directed[i].new_gain);
      end
      // typed values travel with the word they belong to
      typed_req <= directed[i].typed;
      typed_x   <= directed[i].tx;
      typed_y   <= directed[i].ty;
      typed_z   <= directed[i].tz;
      push_setpoint(directed[i].px, directed[i].py, directed[i].pz,
                    directed[i].qw, directed[i].qx, directed[i].qy, directed[i].qz);
    end
    in_tvalid <= 1'b0;
    typed_req <= 1'b0;

    for (int p = 0; p < N_PHASES; p++) begin
      write_gain(p == N_PHASES - 1 ? $urandom_range(0, 131071) : phase_gain[p]);
      if (p == 2) hold_trig++;
      burst = $urandom_range(1, 12);
      for (int n = 0; n < N_RAND; n++) begin
        push_setpoint(rand_position(), rand_position(), rand_position(),
                      rand_quat_part(), rand_quat_part(), rand_quat_part(),
                      rand_quat_part());
        burst--;
        if (burst == 0) begin
          burst = $urandom_range(1, 12);
          if ($urandom_range(0, 3) != 0) begin
            in_tvalid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge clk);
          end
        end
      end
      in_tvalid <= 1'b0;
    end

    while (smoothed_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && smoothed_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/psls_pkg.sv
rtl/psls_front.sv
rtl/psls_queue.sv
rtl/psls_back.sv
rtl/pose_setpoint_lowpass_smoother.sv
dv/tb_pose_setpoint_lowpass_smoother.sv
